// ----- hw/rtl/window3x3_std_mean_top_macros.svh -----
// Assertion macros used by the checker in wsm_checker.sv.
`ifndef WINDOW3X3_STD_MEAN_TOP_MACROS_SVH
`define WINDOW3X3_STD_MEAN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSM_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("window statistics check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("window statistics check failed");

`endif

// ----- hw/rtl/wsm_pkg.sv -----
package wsm_pkg;

  localparam int WINDOW   = 3;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 4;
  localparam int S1_W     = 20;
  localparam int S2_W     = 36;
  localparam int NUM_W    = 39;
  localparam int DEN_W    = 7;
  localparam int STD_DND_W  = NUM_W + 16;
  localparam int MEAN_DND_W = S1_W + 8;
  localparam int SQRT_IN_W  = STD_DND_W - 1;
  localparam int ROOT_W     = SQRT_IN_W / 2;
  localparam int RESULT_W   = 24;
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY = FRONT_STAGES + MEAN_DND_W + STD_DND_W + ROOT_W + 1;

  localparam logic [1:0] EDGE_FIRST = 2'd1;
  localparam logic [1:0] EDGE_LAST  = 2'd2;

  localparam logic [1:0] STATUS_MANY = 2'd0;
  localparam logic [1:0] STATUS_ONE  = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  typedef struct packed {
    logic [STD_DND_W-1:0]  std_dnd;
    logic [DEN_W-1:0]      den;
    logic [MEAN_DND_W-1:0] mean_dnd;
    logic [COUNT_W-1:0]    n;
  } wsm_item_t;

  typedef struct packed {
    logic [STD_DND_W-1:0] std_dnd;
    logic [DEN_W-1:0]     den;
    logic [COUNT_W-1:0]   n;
  } wsm_mside_t;

  typedef struct packed {
    logic [RESULT_W-1:0] mean;
    logic [COUNT_W-1:0]  n;
  } wsm_sside_t;

endpackage

// ----- hw/rtl/window3x3_std_mean_top.sv -----
// Local 3x3 mean and sample standard deviation.
// Input: a transfer happens when start is high and busy is low; busy stays
// low, so one neighborhood can be started in every clock cycle.
// Configuration: the fill value is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write it only while no item is in flight.
// Output: each result is shown for exactly one cycle with result_valid high.
// Path: the front end masks and squares, sums rows, sums the window, forms
// the products and takes their difference; then come the pipelined 28-bit
// mean division, the 55-bit deviation division, the square root of its
// low 54 bits and an output register. Throughput is one item per cycle.
// Reset clears all pipeline valid bits and sets the fill value to 65535.
// The receiver cannot stall, so results are never held back.
module window3x3_std_mean_top
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sample_nw,
  input  logic [15:0] sample_n,
  input  logic [15:0] sample_ne,
  input  logic [15:0] sample_w,
  input  logic [15:0] sample_c,
  input  logic [15:0] sample_e,
  input  logic [15:0] sample_sw,
  input  logic [15:0] sample_s,
  input  logic [15:0] sample_se,
  input  logic [1:0]  row_edge,
  input  logic [1:0]  col_edge,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [23:0] std_dev,
  output logic [23:0] mean_value,
  output logic [3:0]  valid_count,
  output logic [1:0]  status
);

  logic [SAMPLE_W-1:0] fill_value;
  logic [SAMPLE_W-1:0] samples [WINDOW*WINDOW];
  logic                f_valid, m_valid, s_valid, q_valid;
  wsm_item_t           f_item;
  wsm_mside_t          m_in_side, m_out_side;
  wsm_sside_t          s_in_side, q_side;
  wsm_sside_t          s_in_side_q;
  logic [MEAN_DND_W-1:0] mean_quo;
  logic [STD_DND_W-1:0]  std_quo;
  logic [ROOT_W-1:0]     root;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_value <= '1;
    end else if (cfg_valid && cfg_ready) begin
      fill_value <= cfg_data;
    end
  end

  assign samples[0] = sample_nw;
  assign samples[1] = sample_n;
  assign samples[2] = sample_ne;
  assign samples[3] = sample_w;
  assign samples[4] = sample_c;
  assign samples[5] = sample_e;
  assign samples[6] = sample_sw;
  assign samples[7] = sample_s;
  assign samples[8] = sample_se;

  wsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .samples    (samples),
    .row_edge   (row_edge),
    .col_edge   (col_edge),
    .fill_value (fill_value),
    .out_valid  (f_valid),
    .out_item   (f_item)
  );

  assign m_in_side.std_dnd = f_item.std_dnd;
  assign m_in_side.den     = f_item.den;
  assign m_in_side.n       = f_item.n;

  wsm_div #(
    .DW (MEAN_DND_W),
    .VW (COUNT_W),
    .SW ($bits(wsm_mside_t))
  ) u_mean_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_dnd    (f_item.mean_dnd),
    .in_dsr    (f_item.n),
    .in_side   (m_in_side),
    .out_valid (m_valid),
    .out_quo   (mean_quo),
    .out_side  (m_out_side)
  );

  assign s_in_side.mean = mean_quo[RESULT_W-1:0];
  assign s_in_side.n    = m_out_side.n;

  wsm_div #(
    .DW (STD_DND_W),
    .VW (DEN_W),
    .SW ($bits(wsm_sside_t))
  ) u_std_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_dnd    (m_out_side.std_dnd),
    .in_dsr    (m_out_side.den),
    .in_side   (s_in_side),
    .out_valid (s_valid),
    .out_quo   (std_quo),
    .out_side  (q_side)
  );

  wsm_sqrt #(
    .DW (SQRT_IN_W),
    .SW ($bits(wsm_sside_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_val    (std_quo[SQRT_IN_W-1:0]),
    .in_side   (q_side),
    .out_valid (q_valid),
    .out_root  (root),
    .out_side  (s_in_side_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    valid_count <= s_in_side_q.n;
    if (s_in_side_q.n == '0) begin
      std_dev    <= {fill_value, 8'h00};
      mean_value <= {fill_value, 8'h00};
      status     <= STATUS_NONE;
    end else if (s_in_side_q.n == COUNT_W'(1)) begin
      std_dev    <= '0;
      mean_value <= s_in_side_q.mean;
      status     <= STATUS_ONE;
    end else begin
      std_dev    <= root[RESULT_W-1:0];
      mean_value <= s_in_side_q.mean;
      status     <= STATUS_MANY;
    end
  end

endmodule

// ----- hw/rtl/wsm_front.sv -----
module wsm_front
  import wsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [SAMPLE_W-1:0] samples [9],
  input  logic [1:0]          row_edge,
  input  logic [1:0]          col_edge,
  input  logic [SAMPLE_W-1:0] fill_value,
  output logic                out_valid,
  output wsm_item_t           out_item
);

  logic                vld_a, vld_b, vld_c, vld_d;
  logic [8:0]          use_a;
  logic [SAMPLE_W-1:0] val_a [9];
  logic [31:0]         sq_a [9];
  logic [17:0]         s1r_b [3];
  logic [33:0]         s2r_b [3];
  logic [COUNT_W-1:0]  n_b, n_c, n_d;
  logic [S1_W-1:0]     s1_c, s1_d;
  logic [S2_W-1:0]     s2_c;
  logic [NUM_W:0]      p2_d, p1_d;
  logic [DEN_W-1:0]    den_d;
  logic [8:0]          use_next;
  logic [NUM_W:0]      num_full;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      use_next[k] = (samples[k] != fill_value)
                    && !((k / 3 == 0) && (row_edge == EDGE_FIRST))
                    && !((k / 3 == 2) && (row_edge == EDGE_LAST))
                    && !((k % 3 == 0) && (col_edge == EDGE_FIRST))
                    && !((k % 3 == 2) && (col_edge == EDGE_LAST));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a <= in_valid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
      out_valid <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    use_a <= use_next;
    for (int k = 0; k < 9; k++) begin
      val_a[k] <= use_next[k] ? samples[k] : '0;
      sq_a[k]  <= use_next[k] ? 32'(samples[k]) * 32'(samples[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      s1r_b[r] <= 18'(val_a[3*r]) + 18'(val_a[3*r+1]) + 18'(val_a[3*r+2]);
      s2r_b[r] <= 34'(sq_a[3*r]) + 34'(sq_a[3*r+1]) + 34'(sq_a[3*r+2]);
    end
    n_b <= COUNT_W'($countones(use_a));
  end

  always_ff @(posedge clk) begin
    s1_c <= S1_W'(s1r_b[0]) + S1_W'(s1r_b[1]) + S1_W'(s1r_b[2]);
    s2_c <= S2_W'(s2r_b[0]) + S2_W'(s2r_b[1]) + S2_W'(s2r_b[2]);
    n_c  <= n_b;
  end

  always_ff @(posedge clk) begin
    p2_d  <= (NUM_W + 1)'(n_c) * (NUM_W + 1)'(s2_c);
    p1_d  <= (NUM_W + 1)'(s1_c) * (NUM_W + 1)'(s1_c);
    den_d <= DEN_W'(n_c) * (DEN_W'(n_c) - DEN_W'(1));
    s1_d  <= s1_c;
    n_d   <= n_c;
  end

  assign num_full = p2_d - p1_d;

  always_ff @(posedge clk) begin
    out_item.std_dnd  <= {num_full[NUM_W-1:0], 16'h0000};
    out_item.den      <= den_d;
    out_item.mean_dnd <= {s1_d, 8'h00};
    out_item.n        <= n_d;
  end

endmodule

// ----- hw/rtl/wsm_div.sv -----
module wsm_div #(
  parameter int DW = 28,
  parameter int VW = 4,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dnd,
  input  logic [VW-1:0] in_dsr,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld  [DW];
  logic [DW-1:0] dnd  [DW];
  logic [VW-1:0] rem  [DW];
  logic [VW-1:0] dsr  [DW];
  logic [SW-1:0] side [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_dnd;
    logic [VW-1:0] p_rem, p_dsr;
    logic [SW-1:0] p_side;
    logic [VW:0]   trial, diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_dnd  = in_dnd;
      assign p_rem  = '0;
      assign p_dsr  = in_dsr;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_dnd  = dnd[i-1];
      assign p_rem  = rem[i-1];
      assign p_dsr  = dsr[i-1];
      assign p_side = side[i-1];
    end

    assign trial = {p_rem, p_dnd[DW-1]};
    assign ge    = trial >= {1'b0, p_dsr};
    assign diff  = trial - {1'b0, p_dsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[i]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
      dnd[i]  <= {p_dnd[DW-2:0], ge};
      dsr[i]  <= p_dsr;
      side[i] <= p_side;
    end
  end

  assign out_valid = vld[DW-1];
  assign out_quo   = dnd[DW-1];
  assign out_side  = side[DW-1];

endmodule

// ----- hw/rtl/wsm_sqrt.sv -----
module wsm_sqrt #(
  parameter int DW = 54,
  parameter int SW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_val,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [DW/2-1:0]  out_root,
  output logic [SW-1:0]    out_side
);

  localparam int RT = DW / 2;
  localparam int RW = RT + 2;

  logic          vld  [RT];
  logic [DW-1:0] val  [RT];
  logic [RW-1:0] rem  [RT];
  logic [RT-1:0] root [RT];
  logic [SW-1:0] side [RT];

  for (genvar i = 0; i < RT; i++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_val;
    logic [RW-1:0] p_rem, cur, trial;
    logic [RT-1:0] p_root;
    logic [SW-1:0] p_side;
    logic          ge;

    if (i == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_val  = in_val;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_val  = val[i-1];
      assign p_rem  = rem[i-1];
      assign p_root = root[i-1];
      assign p_side = side[i-1];
    end

    assign cur   = {p_rem[RW-3:0], p_val[DW-1:DW-2]};
    assign trial = {p_root, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[i]  <= ge ? cur - trial : cur;
      root[i] <= {p_root[RT-2:0], ge};
      val[i]  <= {p_val[DW-3:0], 2'b00};
      side[i] <= p_side;
    end
  end

  assign out_valid = vld[RT-1];
  assign out_root  = root[RT-1];
  assign out_side  = side[RT-1];

endmodule

// ----- hw/rtl/wsm_checker.sv -----
`include "window3x3_std_mean_top_macros.svh"

module wsm_checker
  import wsm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [23:0] std_dev,
  input logic [3:0]  valid_count,
  input logic [1:0]  status
);

  `WSM_ASSERT_IMPLY(a_result_from_start, clk, rst, result_valid, $past(start && !busy, LATENCY))
  `WSM_ASSERT_IMPLY(a_one_has_zero_dev, clk, rst, result_valid && status == STATUS_ONE, std_dev == '0 && valid_count == 4'd1)
  `WSM_ASSERT_IMPLY(a_none_count, clk, rst, result_valid && valid_count == 4'd0, status == STATUS_NONE)
  `WSM_ASSERT_IMPLY(a_many_count, clk, rst, result_valid && status == STATUS_MANY, valid_count >= 4'd2 && valid_count <= 4'd9)

endmodule

bind window3x3_std_mean_top wsm_checker u_wsm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .std_dev      (std_dev),
  .valid_count  (valid_count),
  .status       (status)
);

// ----- bench/window_stats_checker.sv -----
`timescale 1ns / 1ps
module window_stats_checker
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] sample_nw,
  input  logic [15:0] sample_n,
  input  logic [15:0] sample_ne,
  input  logic [15:0] sample_w,
  input  logic [15:0] sample_c,
  input  logic [15:0] sample_e,
  input  logic [15:0] sample_sw,
  input  logic [15:0] sample_s,
  input  logic [15:0] sample_se,
  input  logic [1:0]  row_edge,
  input  logic [1:0]  col_edge,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        result_valid,
  input  logic [23:0] std_dev,
  input  logic [23:0] mean_value,
  input  logic [3:0]  valid_count,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [23:0] sd;
    logic [23:0] mean;
    logic [3:0]  cnt;
    logic [1:0]  st;
  } stats_t;

  stats_t expected_stats[$];
  logic [15:0] fill_code;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic stats_t window_stats(logic [15:0] px[9], logic [1:0] re,
                                          logic [1:0] ce, logic [15:0] fill);
    stats_t s;
    logic [63:0] n, s1, s2, v;
    n = 0;
    s1 = 0;
    s2 = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v = 64'(px[r*3+c]);
        if (!((r == 0 && re == EDGE_FIRST) || (r == 2 && re == EDGE_LAST) ||
              (c == 0 && ce == EDGE_FIRST) || (c == 2 && ce == EDGE_LAST) ||
              v[15:0] == fill)) begin
          n = n + 1;
          s1 = s1 + v;
          s2 = s2 + v * v;
        end
      end
    end
    if (n > 1) begin
      s.sd = 24'(int_sqrt(((n * s2 - s1 * s1) << 16) / (n * (n - 1))));
      s.mean = 24'((s1 << 8) / n);
      s.st = STATUS_MANY;
    end else if (n == 1) begin
      s.sd = '0;
      s.mean = 24'(s1 << 8);
      s.st = STATUS_ONE;
    end else begin
      s.sd = {fill, 8'd0};
      s.mean = {fill, 8'd0};
      s.st = STATUS_NONE;
    end
    s.cnt = n[3:0];
    return s;
  endfunction

  always @(posedge clk) begin
    logic [15:0] px[9];
    stats_t got, want;
    if (rst) begin
      fill_code <= 16'hFFFF;
      fail_count <= 0;
      pending <= 0;
      expected_stats.delete();
    end else begin
      if (result_valid) begin
        got = '{std_dev, mean_value, valid_count, status};
        if (expected_stats.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_stats.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        px = '{sample_nw, sample_n, sample_ne, sample_w, sample_c, sample_e,
               sample_sw, sample_s, sample_se};
        expected_stats.push_back(window_stats(px, row_edge, col_edge, fill_code));
      end
      if (cfg_valid && cfg_ready) fill_code <= cfg_data;
      pending <= expected_stats.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import wsm_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [15:0] px[9];
  logic [1:0] row_edge = '0, col_edge = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic result_valid;
  logic [23:0] std_dev, mean_value;
  logic [3:0] valid_count;
  logic [1:0] status;
  int fail_count, pending;
  int idle_pct;
  int quiet_cycles = 0;
  logic [15:0] fill_now = 16'hFFFF;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  window3x3_std_mean_top uut (
    .clk, .rst, .start, .busy,
    .sample_nw(px[0]), .sample_n(px[1]), .sample_ne(px[2]),
    .sample_w(px[3]), .sample_c(px[4]), .sample_e(px[5]),
    .sample_sw(px[6]), .sample_s(px[7]), .sample_se(px[8]),
    .row_edge, .col_edge, .cfg_valid, .cfg_ready, .cfg_data,
    .result_valid, .std_dev, .mean_value, .valid_count, .status
  );

  window_stats_checker checker_i (
    .clk, .rst, .start, .busy,
    .sample_nw(px[0]), .sample_n(px[1]), .sample_ne(px[2]),
    .sample_w(px[3]), .sample_c(px[4]), .sample_e(px[5]),
    .sample_sw(px[6]), .sample_s(px[7]), .sample_se(px[8]),
    .row_edge, .col_edge, .cfg_valid, .cfg_ready, .cfg_data,
    .result_valid, .std_dev, .mean_value, .valid_count, .status,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("** window3x3_std_mean_top: FAILED **");
      $finish;
    end
  end

  task automatic send_window(logic [15:0] w[9], logic [1:0] re, logic [1:0] ce);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    px = w;
    row_edge = re;
    col_edge = ce;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task automatic drain_pipeline();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_fill(logic [15:0] value);
    drain_pipeline();
    cfg_data = value;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
    fill_now = value;
  endtask

  task automatic random_window();
    logic [15:0] w[9];
    logic [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < 9; i++) begin
      case ($urandom_range(5))
        0: w[i] = fill_now;
        1: w[i] = 16'(base + $urandom_range(7) - 3);
        2: w[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: w[i] = 16'($urandom);
      endcase
    end
    send_window(w, 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  initial begin
    logic [15:0] w[9];
    int phase_pct[4];
    logic [15:0] fills[4];
    for (int i = 0; i < 9; i++) px[i] = '0;
    phase_pct = '{0, 76, 0, 15};
    fills = '{16'hFFFF, 16'h0000, 16'h8000, 16'h1234};
    idle_pct = 0;
    repeat (12) @(negedge clk);
    rst = 0;
    @(negedge clk);

    for (int i = 0; i < 9; i++) w[i] = 16'hFFFE;
    for (int re = 0; re < 4; re++) begin
      for (int ce = 0; ce < 4; ce++) begin
        send_window(w, 2'(re), 2'(ce));
      end
    end
    for (int i = 0; i < 9; i++) w[i] = 16'hFFFF;
    send_window(w, 2'd0, 2'd0);
    w[4] = 16'h0000;
    send_window(w, 2'd0, 2'd0);
    w[4] = 16'hFFFE;
    send_window(w, 2'd0, 2'd0);
    for (int i = 0; i < 9; i++) w[i] = (i % 2) ? 16'hFFFE : 16'h0000;
    send_window(w, 2'd0, 2'd0);
    send_window(w, EDGE_FIRST, EDGE_LAST);

    write_fill(16'h0000);
    for (int i = 0; i < 9; i++) w[i] = 16'h0000;
    send_window(w, 2'd0, 2'd0);
    w[8] = 16'hFFFF;
    send_window(w, 2'd0, 2'd0);

    for (int p = 0; p < 4; p++) begin
      write_fill(fills[p]);
      idle_pct = phase_pct[p];
      for (int k = 0; k < 500; k++) begin
        random_window();
        if (k == 250) drain_pipeline();
      end
    end

    drain_pipeline();
    if (fail_count == 0) begin
      $display("** window3x3_std_mean_top: PASSED **");
    end else begin
      $display("** window3x3_std_mean_top: FAILED **");
    end
    $finish;
  end

endmodule
